// ===== hw/rtl/ufr_pkg.sv =====
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants of the UBX frame receiver.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam int FRAME_BYTES = 96;
    localparam int POS_W       = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // frame positions
    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_BODY_FIRST  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CK_A        = POS_W'(FRAME_BYTES + 2);
    localparam logic [POS_W-1:0] POS_CK_B        = POS_W'(FRAME_BYTES + 3);

    // reset values of the configuration registers
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP_TIMEOUT = 2'd0,
        CFG_SYNC_FIRST  = 2'd1,
        CFG_SYNC_SECOND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] gap_timeout_ms;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic             store_valid;
        logic [POS_W-1:0] store_index;
        logic [7:0]       store_data;
        logic             frame_ok;
    } t_out_item;

endpackage

// ===== hw/rtl/ubx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_receiver
// UBX frame receiver: sync search, body byte writes and Fletcher-8 check.
// ----------------------------------------------------------------------------
// Input channel: one received byte with its millisecond timestamp per
// transaction (i_in_valid / o_in_stall). Output channel: exactly one result
// per input byte (o_out_valid / i_out_stall) carrying a frame-store write
// (store_valid, store_index, store_data) and the frame_ok pulse on the last
// checksum byte of a good frame.
// The result becomes valid in the cycle after its input transaction; one
// byte per cycle is sustained while i_out_stall is low, set by the single
// result register after the parser. While a result is held and i_out_stall
// is high, o_in_stall is raised and no new byte is taken; when the result
// drains a new byte is taken in the same cycle.
// Configuration registers (gap timeout, sync bytes) are written through
// i_cfg_valid / o_cfg_ready, which is always ready; write only while idle.
// Synchronous reset clears the frame position, sums, last byte time and
// the result valid flag, and restores the default register values.
// ----------------------------------------------------------------------------
module ubx_frame_receiver
    import ufr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;
    logic      full_stalled;
    logic      in_fire;

    assign o_in_stall = full_stalled;
    assign in_fire    = i_in_valid && !full_stalled;

    ufr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ufr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    ufr_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (in_fire),
        .i_result       (result),
        .o_full_stalled (full_stalled),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_item     (o_out_item)
    );

endmodule

// ===== hw/rtl/ufr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ufr_cfg_regs
// Configuration registers: gap timeout and the two sync bytes.
// ----------------------------------------------------------------------------
module ufr_cfg_regs
    import ufr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAP_TIMEOUT: n_cfg.gap_timeout_ms = i_cfg_data;
                CFG_SYNC_FIRST:  n_cfg.sync_first     = i_cfg_data[7:0];
                CFG_SYNC_SECOND: n_cfg.sync_second    = i_cfg_data[7:0];
                default:         n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_timeout_ms <= GAP_TIMEOUT_RST;
            r_cfg.sync_first     <= SYNC_FIRST_RST;
            r_cfg.sync_second    <= SYNC_SECOND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/ufr_parser.sv =====
// ----------------------------------------------------------------------------
// ufr_parser
// Frame position tracking, Fletcher-8 sums and gap timeout for each byte.
// ----------------------------------------------------------------------------
module ufr_parser
    import ufr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_sum_a, n_sum_a;
    logic [7:0]       r_sum_b, n_sum_b;
    logic [31:0]      r_last_time, n_last_time;

    logic [31:0]      gap;
    logic             timed_out;
    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] body_idx;
    logic [7:0]       sum_a_new;

    // wrapped gap since the previous byte, zero time means none
    assign gap       = i_item.time_ms - r_last_time;
    assign timed_out = (r_last_time != 32'd0) && (gap > {16'd0, i_cfg.gap_timeout_ms});
    assign pos_eff   = timed_out ? POS_SYNC_FIRST : r_pos;
    assign body_idx  = pos_eff - POS_BODY_FIRST;
    assign sum_a_new = r_sum_a + i_item.rx_byte;

    always_comb begin
        n_pos       = r_pos;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_last_time = r_last_time;
        o_result    = '0;
        if (i_fire) begin
            n_last_time = i_item.time_ms;
            if (pos_eff == POS_SYNC_FIRST) begin
                n_pos = (i_item.rx_byte == i_cfg.sync_first) ? POS_SYNC_SECOND
                                                             : POS_SYNC_FIRST;
            end else if (pos_eff == POS_SYNC_SECOND) begin
                n_pos = (i_item.rx_byte == i_cfg.sync_second) ? POS_BODY_FIRST
                                                              : POS_SYNC_FIRST;
            end else if (pos_eff < POS_CK_A) begin
                o_result.store_valid = 1'b1;
                o_result.store_index = body_idx;
                o_result.store_data  = i_item.rx_byte;
                // sums restart on the first body byte
                if (pos_eff == POS_BODY_FIRST) begin
                    n_sum_a = i_item.rx_byte;
                    n_sum_b = i_item.rx_byte;
                end else begin
                    n_sum_a = sum_a_new;
                    n_sum_b = r_sum_b + sum_a_new;
                end
                n_pos = pos_eff + POS_W'(1);
            end else if (pos_eff == POS_CK_A) begin
                n_pos = (i_item.rx_byte == r_sum_a) ? POS_CK_B : POS_SYNC_FIRST;
            end else if (pos_eff == POS_CK_B) begin
                o_result.frame_ok = (i_item.rx_byte == r_sum_b);
                n_pos             = POS_SYNC_FIRST;
            end else begin
                n_pos = POS_SYNC_FIRST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_SYNC_FIRST;
            r_sum_a     <= 8'd0;
            r_sum_b     <= 8'd0;
            r_last_time <= 32'd0;
        end else begin
            r_pos       <= n_pos;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_last_time <= n_last_time;
        end
    end

endmodule

// ===== hw/rtl/ufr_out_reg.sv =====
// ----------------------------------------------------------------------------
// ufr_out_reg
// Result register with valid/stall handshake towards the consumer.
// ----------------------------------------------------------------------------
module ufr_out_reg
    import ufr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_result,
    output logic      o_full_stalled,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_valid, n_valid;
    t_out_item r_item;

    // a held result blocks new transactions only while the consumer stalls
    assign o_full_stalled = r_valid && i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_out_item     = r_item;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

endmodule
